/* sv/ams_pkg.sv */
// shared types and constants for the adjacency matrix graph store
`default_nettype none

package ams_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int ID_W             = 32;
  localparam int COUNT_W          = 6;
  localparam int FUNC_W           = 2;

  // function codes of an input transfer
  localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QRY_SUCC  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QRY_PRED  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNDEFINED = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_ADD_SRC,
    S_ADD_DST,
    S_EDGE_RD,
    S_EDGE_WR,
    S_ROW_RD,
    S_SCAN,
    S_DONE
  } state_t;

  // read and write strobes of one memory port pair
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* sv/ams_if.sv */
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface ams_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] src_id;
  logic signed [31:0] dst_id;

  modport source (output valid, func, src_id, dst_id, input ready);
  modport sink   (input valid, func, src_id, dst_id, output ready);
endinterface

interface ams_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] neighbor_id;
  logic               has_neighbor;
  logic               vertex_known;
  logic               table_full;
  logic [5:0]         vertex_count;
  logic               last;

  modport source (output valid, neighbor_id, has_neighbor, vertex_known, table_full,
                  vertex_count, last, input ready);
  modport sink   (input valid, neighbor_id, has_neighbor, vertex_known, table_full,
                  vertex_count, last, output ready);
endinterface

`default_nettype wire

/* sv/ams_ram.sv */
// single port pair synchronous ram with registered read data
`default_nettype none

module ams_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire ams_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic [WIDTH-1:0] rdata_r
);
  import ams_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read, read data held while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* sv/ams_ctrl.sv */
// sequencer: id search, vertex registration, edge update and neighbor scan
`default_nettype none

module ams_ctrl #(
  parameter int MAXV = ams_pkg::MAX_VERTICES_DEF,
  parameter int IW   = $clog2(MAXV),
  parameter int CW   = $clog2(MAXV + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ams_in_if.sink                 in_ch,
  ams_out_if.source              out_ch,
  output      ams_pkg::mem_ctl_t id_ctl,
  output      logic [IW-1:0]     id_addr,
  output      logic [31:0]       id_wdata,
  input  wire logic [31:0]       id_rdata,
  output      ams_pkg::mem_ctl_t edge_ctl,
  output      logic [IW-1:0]     edge_addr,
  output      logic [MAXV-1:0]   edge_wdata,
  input  wire logic [MAXV-1:0]   edge_rdata
);
  import ams_pkg::*;

  state_t            state_r, state_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [31:0]       src_r;
  logic [31:0]       dst_r;
  logic [CW-1:0]     used_r;
  logic [CW-1:0]     idx_r;
  logic              pend_r;
  logic [IW-1:0]     pend_idx_r;
  logic              sf_r;
  logic [IW-1:0]     si_r;
  logic              df_r;
  logic [IW-1:0]     di_r;
  logic              hold_r;
  logic [31:0]       hold_id_r;
  logic              known_r;
  logic              full_r;

  logic              out_valid_r;
  logic [31:0]       out_nid_r;
  logic              out_has_r;
  logic              out_known_r;
  logic              out_full_r;
  logic [CW-1:0]     out_count_r;
  logic              out_last_r;

  logic              accept;
  logic              issue;
  logic              out_free;
  logic              hit;
  logic              stall;
  logic              too_full;
  logic [CW:0]       need;
  logic              push;
  logic [31:0]       push_nid;
  logic              push_has;
  logic              push_known;
  logic              push_full;
  logic              push_last;

  assign accept   = in_ch.valid && in_ch.ready;
  assign issue    = idx_r < used_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // vertices an add edge would register, and the capacity check
  always_comb begin
    need = '0;
    if (!sf_r) begin
      need = need + 1'b1;
    end
    if (!df_r && !(!sf_r && src_r == dst_r)) begin
      need = need + 1'b1;
    end
    too_full = ({1'b0, used_r} + need) > (CW + 1)'(MAXV);
  end

  // neighbor hit of the entry whose read data is back this cycle
  always_comb begin
    if (func_r == FUNC_QRY_SUCC) begin
      hit = pend_r && edge_rdata[pend_idx_r];
    end else begin
      hit = pend_r && edge_rdata[si_r];
    end
    stall = hit && hold_r && !out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.func == FUNC_UNDEFINED) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!issue && !pend_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (func_r == FUNC_ADD_EDGE) begin
          state_nxt = too_full ? S_DONE : S_ADD_SRC;
        end else if (!sf_r) begin
          state_nxt = S_DONE;
        end else if (func_r == FUNC_QRY_SUCC) begin
          state_nxt = S_ROW_RD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_ADD_SRC: state_nxt = S_ADD_DST;
      S_ADD_DST: state_nxt = S_EDGE_RD;
      S_EDGE_RD: state_nxt = S_EDGE_WR;
      S_EDGE_WR: state_nxt = S_DONE;
      S_ROW_RD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory strobes, addresses and result pushes per state
  always_comb begin
    in_ch.ready = 1'b0;
    id_ctl      = '0;
    id_addr     = idx_r[IW-1:0];
    id_wdata    = src_r;
    edge_ctl    = '0;
    edge_addr   = idx_r[IW-1:0];
    edge_wdata  = '0;
    push        = 1'b0;
    push_nid    = hold_id_r;
    push_has    = 1'b0;
    push_known  = 1'b0;
    push_full   = 1'b0;
    push_last   = 1'b0;
    unique case (state_r) inside
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_SEARCH: begin
        id_ctl.re = issue;
      end
      S_ADD_SRC: begin
        id_addr     = used_r[IW-1:0];
        edge_addr   = used_r[IW-1:0];
        id_ctl.we   = !sf_r;
        edge_ctl.we = !sf_r;
      end
      S_ADD_DST: begin
        id_addr     = used_r[IW-1:0];
        id_wdata    = dst_r;
        edge_addr   = used_r[IW-1:0];
        id_ctl.we   = !df_r;
        edge_ctl.we = !df_r;
      end
      S_EDGE_RD, S_ROW_RD: begin
        edge_addr   = si_r;
        edge_ctl.re = 1'b1;
      end
      S_EDGE_WR: begin
        edge_addr   = si_r;
        edge_ctl.we = 1'b1;
        edge_wdata  = edge_rdata | ({{(MAXV-1){1'b0}}, 1'b1} << di_r);
      end
      S_SCAN: begin
        if (!stall) begin
          id_ctl.re   = issue;
          edge_ctl.re = issue && (func_r == FUNC_QRY_PRED);
        end
        // a new hit releases the one held before it
        push       = hit && hold_r && out_free;
        push_has   = 1'b1;
        push_known = 1'b1;
      end
      S_DONE: begin
        push       = out_free;
        push_nid   = hold_r ? hold_id_r : '0;
        push_has   = hold_r;
        push_known = known_r;
        push_full  = full_r;
        push_last  = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r  <= in_ch.func;
            src_r   <= in_ch.src_id;
            dst_r   <= in_ch.dst_id;
            idx_r   <= '0;
            pend_r  <= 1'b0;
            sf_r    <= 1'b0;
            df_r    <= 1'b0;
            hold_r  <= 1'b0;
            known_r <= 1'b0;
            full_r  <= 1'b0;
          end
        end
        S_SEARCH: begin
          // one table entry issued per cycle, compared in the cycle after its read
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          pend_r     <= issue;
          pend_idx_r <= idx_r[IW-1:0];
          if (pend_r && !sf_r && id_rdata == src_r) begin
            sf_r <= 1'b1;
            si_r <= pend_idx_r;
          end
          if (pend_r && !df_r && id_rdata == dst_r) begin
            df_r <= 1'b1;
            di_r <= pend_idx_r;
          end
        end
        S_DECIDE: begin
          idx_r   <= '0;
          pend_r  <= 1'b0;
          full_r  <= (func_r == FUNC_ADD_EDGE) && too_full;
          known_r <= (func_r != FUNC_ADD_EDGE) && sf_r;
        end
        S_ADD_SRC: begin
          if (!sf_r) begin
            sf_r   <= 1'b1;
            si_r   <= used_r[IW-1:0];
            used_r <= used_r + 1'b1;
            // self loop on a new vertex needs one slot only
            if (src_r == dst_r) begin
              df_r <= 1'b1;
              di_r <= used_r[IW-1:0];
            end
          end
        end
        S_ADD_DST: begin
          if (!df_r) begin
            df_r   <= 1'b1;
            di_r   <= used_r[IW-1:0];
            used_r <= used_r + 1'b1;
          end
        end
        S_EDGE_WR: begin
          known_r <= 1'b1;
        end
        S_SCAN: begin
          if (!stall) begin
            if (issue) begin
              idx_r <= idx_r + 1'b1;
            end
            pend_r     <= issue;
            pend_idx_r <= idx_r[IW-1:0];
            if (hit) begin
              hold_r    <= 1'b1;
              hold_id_r <= id_rdata;
            end
          end
        end
        default: begin
          pend_r <= pend_r;
        end
      endcase
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_nid_r   <= push_nid;
      out_has_r   <= push_has;
      out_known_r <= push_known;
      out_full_r  <= push_full;
      out_count_r <= used_r;
      out_last_r  <= push_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.neighbor_id  = out_nid_r;
  assign out_ch.has_neighbor = out_has_r;
  assign out_ch.vertex_known = out_known_r;
  assign out_ch.table_full   = out_full_r;
  assign out_ch.vertex_count = COUNT_W'(out_count_r);
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

/* sv/adjacency_matrix_graph_store_core.sv */
// top level of the adjacency matrix directed graph store
//
//   channel   dir   transfer when    payload
//   in_ch     in    valid && ready   func, src_id, dst_id
//   out_ch    out   valid && ready   neighbor_id, has_neighbor, vertex_known,
//                                    table_full, vertex_count, last
//
// the id search and the neighbor scan each step one memory entry per cycle
// through the id table and adjacency row memories, the scan only while the
// output does not stall it.
// reset clears the vertex count and the sequencer state, not the memories;
// rows are cleared as vertices register.
// a new item is taken while the last result still waits in the output
// register; a stalled output holds the neighbor scan.
`default_nettype none

module adjacency_matrix_graph_store_core #(
  parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ams_in_if.sink    in_ch,
  ams_out_if.source out_ch
);
  import ams_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  mem_ctl_t                id_ctl;
  logic [IW-1:0]           id_addr;
  logic [31:0]             id_wdata;
  logic [31:0]             id_rdata;
  mem_ctl_t                edge_ctl;
  logic [IW-1:0]           edge_addr;
  logic [MAX_VERTICES-1:0] edge_wdata;
  logic [MAX_VERTICES-1:0] edge_rdata;

  // sequencer
  ams_ctrl #(
    .MAXV (MAX_VERTICES),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .id_ctl     (id_ctl),
    .id_addr    (id_addr),
    .id_wdata   (id_wdata),
    .id_rdata   (id_rdata),
    .edge_ctl   (edge_ctl),
    .edge_addr  (edge_addr),
    .edge_wdata (edge_wdata),
    .edge_rdata (edge_rdata)
  );

  // index to id table
  ams_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_VERTICES),
    .AW    (IW)
  ) u_id_ram (
    .clk     (clk),
    .ctl     (id_ctl),
    .addr    (id_addr),
    .wdata   (id_wdata),
    .rdata_r (id_rdata)
  );

  // adjacency rows, bit j of row i is edge i to j
  ams_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES),
    .AW    (IW)
  ) u_edge_ram (
    .clk     (clk),
    .ctl     (edge_ctl),
    .addr    (edge_addr),
    .wdata   (edge_wdata),
    .rdata_r (edge_rdata)
  );

endmodule

`default_nettype wire
